// ===== sv/paired_peer_table_lru_unit_defines.svh =====
// Assertion macros shared by the paired peer table RTL.
`ifndef PAIRED_PEER_TABLE_LRU_UNIT_DEFINES_SVH
`define PAIRED_PEER_TABLE_LRU_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PPTL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PPTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pptl_pkg.sv =====
// Shared constants and types of the paired peer table.
`default_nettype none

package pptl_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int OP_W   = 3;
   localparam int MAC_W  = 48;
   localparam int KEY_W  = 64;
   localparam int CHAN_W = 4;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
   localparam logic [OP_W-1:0] OP_READ   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [CHAN_W-1:0] chan;
   } entry_type;

   typedef struct packed {
      logic shift;   // take the upper neighbor's entry
      logic load;    // take the appended entry
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== sv/pptl_cell.sv =====
// One table slot: holds an entry, shifts from its neighbor, flags a MAC match.
`default_nettype none

module pptl_cell
   import pptl_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire entry_type         next_entry,
   input  wire entry_type         load_entry,
   input  wire logic [MAC_W-1:0]  cmp_mac,
   output entry_type              entry_q,
   output logic                   match_q
);

   entry_type entry_ff;
   logic      match_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= load_entry;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
      match_ff <= (entry_ff.mac == cmp_mac);
   end

   assign entry_q = entry_ff;
   assign match_q = match_ff;

endmodule

`default_nettype wire

// ===== sv/paired_peer_table_lru_unit.sv =====
// Top level of the paired peer table: cell row, sequencer and response register.
//
// Usage:
//   req_*  : one request per valid/ready handshake (add, delete, find, read, clear).
//   rsp_*  : one response per request, in request order, held until rsp_ready.
//   csr_*  : capacity write (max_entries), always ready; write only while idle.
// The table is a row of TABLE_DEPTH cells, oldest entry in cell 0. Each cell
// compares its MAC against the request MAC and registers the flag; the
// sequencer walks those flags one slot per cycle. Removing an entry makes every
// cell at and above the hole take its upper neighbor's entry at once.
// Steps from accept to response:
//   read, clear, unused codes : straight to the response register
//   find, delete              : compare, then scan up to count slots
//   add                       : scan and remove a repeat, evict the oldest entries
//                               while at capacity, then append.
// A new request is taken once the sequencer is idle, while the previous
// response may still wait in the output register. A stalled rsp_ready holds the
// sequencer in its final step until the response register frees.
// Reset: table empty, capacity 16, no response pending.
`default_nettype none

`include "paired_peer_table_lru_unit_defines.svh"

module paired_peer_table_lru_unit
   import pptl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [MAC_W-1:0]   req_peer_mac,
   input  wire logic [KEY_W-1:0]   req_key_high,
   input  wire logic [KEY_W-1:0]   req_key_low,
   input  wire logic [CHAN_W-1:0]  req_radio_channel,
   input  wire logic [IDX_W-1:0]   req_read_index,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [IDX_W-1:0]        rsp_entry_index,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic                    rsp_evicted,
   output logic [MAC_W-1:0]        rsp_out_mac,
   output logic [KEY_W-1:0]        rsp_out_key_high,
   output logic [KEY_W-1:0]        rsp_out_key_low,
   output logic [CHAN_W-1:0]       rsp_out_channel,
   // capacity register
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CNT_W-1:0]   csr_max_entries
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_REMOVE,
      ST_EVICT,
      ST_APPEND,
      ST_FINISH
   } state_type;

   state_type          state_ff;

   // request capture
   logic [OP_W-1:0]    op_ff;
   logic [MAC_W-1:0]   mac_ff;
   logic [KEY_W-1:0]   key_high_ff;
   logic [KEY_W-1:0]   key_low_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [IDX_W-1:0]   rd_ff;

   // table control
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   max_entries_ff;
   logic [CNT_W-1:0]   scan_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic               evicted_ff;

   // response register
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic               rsp_evicted_ff;
   entry_type          rsp_entry_ff;

   logic [CNT_W-1:0]   cap;
   logic               at_cap;
   logic               shifting;
   logic [IDX_W-1:0]   rm_idx;
   logic [IDX_W-1:0]   sel_idx;
   logic               rd_ok;
   entry_type          new_entry;
   entry_type          entry_q  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] match_q;
   cell_ctl_type       cell_ctl [TABLE_DEPTH];

   // Saturate capacity into 1..TABLE_DEPTH.
   always_comb begin
      priority if (max_entries_ff == '0) begin
         cap = CNT_W'(1);
      end else if (max_entries_ff > CNT_W'(TABLE_DEPTH)) begin
         cap = CNT_W'(TABLE_DEPTH);
      end else begin
         cap = max_entries_ff;
      end
   end

   assign at_cap = (count_ff >= cap);

   // Drop a hit in REMOVE; drop the oldest entry in EVICT.
   assign shifting = (state_ff == ST_REMOVE) || ((state_ff == ST_EVICT) && at_cap);
   assign rm_idx   = (state_ff == ST_REMOVE) ? hit_idx_ff : '0;

   assign new_entry = '{mac: mac_ff, key_high: key_high_ff, key_low: key_low_ff,
                        chan: chan_ff};

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_ctl[i].shift = shifting && (IDX_W'(i) >= rm_idx);
         cell_ctl[i].load  = (state_ff == ST_APPEND) &&
                             (count_ff[IDX_W-1:0] == IDX_W'(i));
      end
   end

   // Row of cells; each takes its upper neighbor, the top one takes an empty slot.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_type upper;
      if (g == TABLE_DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = entry_q[g+1];
      end
      pptl_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .next_entry (upper),
         .load_entry (new_entry),
         .cmp_mac    (mac_ff),
         .entry_q    (entry_q[g]),
         .match_q    (match_q[g])
      );
   end

   assign sel_idx = (op_ff == OP_READ) ? rd_ff : hit_idx_ff;
   assign rd_ok   = ({1'b0, rd_ff} < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         max_entries_ff <= CNT_W'(TABLE_DEPTH);
         rsp_valid_ff   <= 1'b0;
         hit_ff         <= 1'b0;
         evicted_ff     <= 1'b0;
         scan_ff        <= '0;
      end else begin
         if (csr_valid) begin
            max_entries_ff <= csr_max_entries;
         end
         // Release the response once taken; FINISH refills it in the same cycle.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff       <= req_operation;
                  mac_ff      <= req_peer_mac;
                  key_high_ff <= req_key_high;
                  key_low_ff  <= req_key_low;
                  chan_ff     <= req_radio_channel;
                  rd_ff       <= req_read_index;
                  hit_ff      <= 1'b0;
                  hit_idx_ff  <= '0;
                  evicted_ff  <= 1'b0;
                  scan_ff     <= '0;
                  unique case (req_operation)
                     OP_ADD, OP_DELETE, OP_FIND: state_ff <= ST_PREP;
                     OP_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= ST_FINISH;
                     end
                     default: state_ff <= ST_FINISH;
                  endcase
               end
            end

            // Wait for the cells to register their compare flags.
            ST_PREP: state_ff <= ST_SCAN;

            ST_SCAN: begin
               if (scan_ff >= count_ff) begin
                  state_ff <= (op_ff == OP_ADD) ? ST_EVICT : ST_FINISH;
               end else if (match_q[scan_ff[IDX_W-1:0]]) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= scan_ff[IDX_W-1:0];
                  state_ff   <= (op_ff == OP_FIND) ? ST_FINISH : ST_REMOVE;
               end else begin
                  scan_ff <= scan_ff + CNT_W'(1);
               end
            end

            ST_REMOVE: begin
               count_ff <= count_ff - CNT_W'(1);
               state_ff <= (op_ff == OP_ADD) ? ST_EVICT : ST_FINISH;
            end

            // Drop the oldest entry until one slot is free under capacity.
            ST_EVICT: begin
               if (at_cap) begin
                  count_ff   <= count_ff - CNT_W'(1);
                  evicted_ff <= 1'b1;
               end else begin
                  state_ff <= ST_APPEND;
               end
            end

            ST_APPEND: begin
               hit_idx_ff <= count_ff[IDX_W-1:0];
               count_ff   <= count_ff + CNT_W'(1);
               state_ff   <= ST_FINISH;
            end

            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_count_ff   <= count_ff;
                  rsp_evicted_ff <= evicted_ff;
                  rsp_status_ff  <= STAT_DONE;
                  rsp_index_ff   <= '0;
                  rsp_entry_ff   <= '0;
                  unique case (op_ff)
                     OP_ADD: rsp_index_ff <= hit_idx_ff;
                     OP_DELETE: begin
                        if (hit_ff) begin
                           rsp_index_ff <= hit_idx_ff;
                        end else begin
                           rsp_status_ff <= STAT_NOT_FOUND;
                        end
                     end
                     OP_FIND: begin
                        if (hit_ff) begin
                           rsp_index_ff <= hit_idx_ff;
                           rsp_entry_ff <= entry_q[sel_idx];
                        end else begin
                           rsp_status_ff <= STAT_NOT_FOUND;
                        end
                     end
                     OP_READ: begin
                        rsp_index_ff <= rd_ff;
                        if (rd_ok) begin
                           rsp_entry_ff <= entry_q[sel_idx];
                        end else begin
                           rsp_status_ff <= STAT_RANGE;
                        end
                     end
                     default: rsp_index_ff <= '0;
                  endcase
                  state_ff <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_out_mac      = rsp_entry_ff.mac;
   assign rsp_out_key_high = rsp_entry_ff.key_high;
   assign rsp_out_key_low  = rsp_entry_ff.key_low;
   assign rsp_out_channel  = rsp_entry_ff.chan;

   // Table never holds more entries than it has cells.
   `PPTL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH),
      "entry count exceeds table depth")
   // An append always lands below the capacity in use.
   `PPTL_ASSERT_NOW(a_append_room, state_ff == ST_APPEND, count_ff < cap,
      "append with table at capacity")
   // An eviction step marks the request as having evicted.
   `PPTL_ASSERT_NEXT(a_evict_flag, (state_ff == ST_EVICT) && at_cap, evicted_ff,
      "eviction not flagged")
   // The scan pointer never passes the valid entries.
   `PPTL_ASSERT_NOW(a_scan_bound, state_ff == ST_SCAN, scan_ff <= count_ff,
      "scan pointer past entry count")

endmodule

`default_nettype wire

// ===== tb/sv/paired_peer_table_lru_unit_test.sv =====
// Self-checking testbench for the paired peer table with oldest-first replacement.
`timescale 1ns / 100ps

module paired_peer_table_lru_unit_test
   import pptl_pkg::*;
();

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 3;
   localparam int RANDOM_ITEMS   = 930;
   localparam int MAC_POOL       = 20;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = TABLE_DEPTH + 16;
   localparam int TIMEOUT_CYCLES = 300000;

   // Codes the block treats as no-ops.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};
   localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [MAC_W-1:0]  mac;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [CHAN_W-1:0] chan;
      logic [IDX_W-1:0]  read_index;
   } peer_request_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  index;
      logic [CNT_W-1:0]  count;
      logic              evicted;
      logic [MAC_W-1:0]  mac;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [CHAN_W-1:0] chan;
   } peer_result_type;

   // One step of the stimulus script: a request, a capacity write, or a pause
   // that waits for every outstanding response.
   typedef enum logic [1:0] {STEP_REQUEST, STEP_CAPACITY, STEP_DRAIN} step_kind_type;

   typedef struct packed {
      step_kind_type    kind;
      peer_request_type req;
      logic [CNT_W-1:0] cap;
      logic [1:0]       pace;   // 0 no idling, 1 light, 2 heavy
   } table_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [OP_W-1:0]    req_operation     = '0;
   logic [MAC_W-1:0]   req_peer_mac      = '0;
   logic [KEY_W-1:0]   req_key_high      = '0;
   logic [KEY_W-1:0]   req_key_low       = '0;
   logic [CHAN_W-1:0]  req_radio_channel = '0;
   logic [IDX_W-1:0]   req_read_index    = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [STAT_W-1:0]  rsp_status;
   logic [IDX_W-1:0]   rsp_entry_index;
   logic [CNT_W-1:0]   rsp_entry_count;
   logic               rsp_evicted;
   logic [MAC_W-1:0]   rsp_out_mac;
   logic [KEY_W-1:0]   rsp_out_key_high;
   logic [KEY_W-1:0]   rsp_out_key_low;
   logic [CHAN_W-1:0]  rsp_out_channel;
   logic               csr_valid         = 1'b0;
   logic               csr_ready;
   logic [CNT_W-1:0]   csr_max_entries   = '0;

   paired_peer_table_lru_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_peer_mac      (req_peer_mac),
      .req_key_high      (req_key_high),
      .req_key_low       (req_key_low),
      .req_radio_channel (req_radio_channel),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_evicted       (rsp_evicted),
      .rsp_out_mac       (rsp_out_mac),
      .rsp_out_key_high  (rsp_out_key_high),
      .rsp_out_key_low   (rsp_out_key_low),
      .rsp_out_channel   (rsp_out_channel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_entries   (csr_max_entries)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow of the peer table. Entries stay packed at 0..peer_count-1,
   // oldest first; every slot above the count is kept at zero.
   // ------------------------------------------------------------------
   logic [MAC_W-1:0]  peer_mac   [TABLE_DEPTH];
   logic [KEY_W-1:0]  peer_key_hi[TABLE_DEPTH];
   logic [KEY_W-1:0]  peer_key_lo[TABLE_DEPTH];
   logic [CHAN_W-1:0] peer_chan  [TABLE_DEPTH];
   int                peer_count;
   logic [CNT_W-1:0]  capacity_reg;

   table_step_type  table_steps[$];     // script consumed by the request driver
   peer_result_type due_responses[$];   // predicted responses, oldest first
   logic [MAC_W-1:0] mac_pool[MAC_POOL];

   logic       req_fire = 1'b0;      // request taken at the last rising edge
   logic       csr_fire = 1'b0;      // capacity write taken at the last rising edge
   logic [1:0] pace_now = '0;        // idling level of the current segment
   int         gap_left, settle_left, stall_left;
   int         failures, n_responses, n_evictions, n_hits, n_csr_writes;

   function automatic void wipe_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         peer_mac[i]    = '0;
         peer_key_hi[i] = '0;
         peer_key_lo[i] = '0;
         peer_chan[i]   = '0;
      end
      peer_count = 0;
   endfunction

   // Remove one entry, pull the newer ones down and zero the freed top slot.
   function automatic void drop_slot(int slot);
      for (int j = slot; j + 1 < peer_count; j++) begin
         peer_mac[j]    = peer_mac[j+1];
         peer_key_hi[j] = peer_key_hi[j+1];
         peer_key_lo[j] = peer_key_lo[j+1];
         peer_chan[j]   = peer_chan[j+1];
      end
      peer_mac[peer_count-1]    = '0;
      peer_key_hi[peer_count-1] = '0;
      peer_key_lo[peer_count-1] = '0;
      peer_chan[peer_count-1]   = '0;
      peer_count--;
   endfunction

   // Only valid entries take part in the search, so zeroed slots never match.
   function automatic int lookup_peer(logic [MAC_W-1:0] mac);
      for (int i = 0; i < peer_count; i++)
         if (peer_mac[i] == mac) return i;
      return -1;
   endfunction

   // Apply one request to the shadow table and return the response it causes.
   function automatic peer_result_type peer_table_apply(peer_request_type r);
      peer_result_type res;
      int hit;
      int cap;
      res = '0;
      res.status = STAT_DONE;
      // Capacity saturates into 1..TABLE_DEPTH.
      cap = (capacity_reg == 0) ? 1 :
            (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
      case (r.op)
         OP_ADD: begin
            hit = lookup_peer(r.mac);
            if (hit >= 0) drop_slot(hit);
            // A lowered capacity can drop several of the oldest entries at once.
            while (peer_count >= cap) begin
               drop_slot(0);
               res.evicted = 1'b1;
            end
            res.index              = IDX_W'(peer_count);
            peer_mac[peer_count]    = r.mac;
            peer_key_hi[peer_count] = r.key_high;
            peer_key_lo[peer_count] = r.key_low;
            peer_chan[peer_count]   = r.chan;
            peer_count++;
         end
         OP_DELETE: begin
            hit = lookup_peer(r.mac);
            if (hit >= 0) begin
               res.index = IDX_W'(hit);
               drop_slot(hit);
            end else begin
               res.status = STAT_NOT_FOUND;
            end
         end
         OP_FIND: begin
            hit = lookup_peer(r.mac);
            if (hit >= 0) begin
               res.index    = IDX_W'(hit);
               res.mac      = peer_mac[hit];
               res.key_high = peer_key_hi[hit];
               res.key_low  = peer_key_lo[hit];
               res.chan     = peer_chan[hit];
            end else begin
               res.status = STAT_NOT_FOUND;
            end
         end
         OP_READ: begin
            res.index = r.read_index;
            if (r.read_index < peer_count) begin
               res.mac      = peer_mac[r.read_index];
               res.key_high = peer_key_hi[r.read_index];
               res.key_low  = peer_key_lo[r.read_index];
               res.chan     = peer_chan[r.read_index];
            end else begin
               res.status = STAT_RANGE;
            end
         end
         OP_CLEAR: wipe_table();
         default: ;   // spare codes leave the table alone
      endcase
      res.count = CNT_W'(peer_count);
      return res;
   endfunction

   function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                       logic [KEY_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers: append steps to the script.
   // ------------------------------------------------------------------
   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom, $urandom});
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic push_request(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac,
                               logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl,
                               logic [CHAN_W-1:0] chan, logic [IDX_W-1:0] idx,
                               logic [1:0] pace);
      table_step_type s;
      s      = '0;
      s.kind = STEP_REQUEST;
      s.req  = '{op: op, mac: mac, key_high: kh, key_low: kl, chan: chan,
                 read_index: idx};
      s.pace = pace;
      table_steps.push_back(s);
   endtask

   task automatic push_drain();
      table_step_type s;
      s      = '0;
      s.kind = STEP_DRAIN;
      table_steps.push_back(s);
   endtask

   // Capacity is only written with the block idle, so drain first.
   task automatic push_capacity(logic [CNT_W-1:0] value);
      table_step_type s;
      push_drain();
      s      = '0;
      s.kind = STEP_CAPACITY;
      s.cap  = value;
      table_steps.push_back(s);
   endtask

   // ------------------------------------------------------------------
   // Request and capacity driver: change inputs on the falling edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      table_step_type nxt;
      logic           slot_free;
      if (reset) begin
         req_valid   <= 1'b0;
         csr_valid   <= 1'b0;
         gap_left    = 0;
         settle_left = SETTLE_CYCLES;
      end else begin
         // Hold valid and payload until the handshake completes.
         slot_free = (!req_valid || req_fire) && (!csr_valid || csr_fire);
         if (!slot_free) begin
            // hold
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else if (table_steps.size() == 0) begin
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else begin
            nxt = table_steps[0];
            case (nxt.kind)
               STEP_DRAIN: begin
                  // Wait for every outstanding response, then let the settle counter run out.
                  req_valid <= 1'b0;
                  csr_valid <= 1'b0;
                  if (due_responses.size() != 0) begin
                     settle_left = SETTLE_CYCLES;
                  end else if (settle_left != 0) begin
                     settle_left--;
                  end else begin
                     void'(table_steps.pop_front());
                     settle_left = SETTLE_CYCLES;
                  end
               end
               STEP_CAPACITY: begin
                  req_valid       <= 1'b0;
                  csr_valid       <= 1'b1;
                  csr_max_entries <= nxt.cap;
                  void'(table_steps.pop_front());
               end
               default: begin
                  csr_valid <= 1'b0;
                  // Random idle burst, more often in heavy segments.
                  if (nxt.pace != 0 &&
                      $urandom_range(0, (nxt.pace == 1) ? 7 : 3) == 0) begin
                     req_valid <= 1'b0;
                     gap_left  = $urandom_range(0, 4);
                  end else begin
                     req_valid         <= 1'b1;
                     req_operation     <= nxt.req.op;
                     req_peer_mac      <= nxt.req.mac;
                     req_key_high      <= nxt.req.key_high;
                     req_key_low       <= nxt.req.key_low;
                     req_radio_channel <= nxt.req.chan;
                     req_read_index    <= nxt.req.read_index;
                     pace_now          <= nxt.pace;
                     void'(table_steps.pop_front());
                  end
               end
            endcase
         end
      end
   end

   // Response side backpressure: random stalls, more often in heavy segments.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (pace_now != 0 &&
                   $urandom_range(0, (pace_now == 1) ? 7 : 3) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample handshakes on the rising edge, predict and compare.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      peer_result_type  want;
      peer_request_type taken;
      if (reset) begin
         req_fire <= 1'b0;
         csr_fire <= 1'b0;
         wipe_table();
         capacity_reg = CNT_W'(TABLE_DEPTH);
      end else begin
         req_fire <= req_valid && req_ready;
         csr_fire <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            capacity_reg = csr_max_entries;
            n_csr_writes++;
         end
         // Retire the oldest prediction before queuing a new one.
         if (rsp_valid && rsp_ready) begin
            n_responses++;
            if (due_responses.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = due_responses.pop_front();
               check_field("status",       want.status,   rsp_status);
               check_field("entry_index",  want.index,    rsp_entry_index);
               check_field("entry_count",  want.count,    rsp_entry_count);
               check_field("evicted",      want.evicted,  rsp_evicted);
               check_field("out_mac",      want.mac,      rsp_out_mac);
               check_field("out_key_high", want.key_high, rsp_out_key_high);
               check_field("out_key_low",  want.key_low,  rsp_out_key_low);
               check_field("out_channel",  want.chan,     rsp_out_channel);
            end
         end
         if (req_valid && req_ready) begin
            taken = '{op: req_operation, mac: req_peer_mac, key_high: req_key_high,
                      key_low: req_key_low, chan: req_radio_channel,
                      read_index: req_read_index};
            want = peer_table_apply(taken);
            if (want.evicted) n_evictions++;
            if ((taken.op == OP_FIND || taken.op == OP_DELETE) &&
                want.status == STAT_DONE)
               n_hits++;
            due_responses.push_back(want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Script, reset and end of run.
   // ------------------------------------------------------------------
   initial begin : script
      logic [MAC_W-1:0]  mac_a, mac_b, mac_c, mac_d;
      logic [OP_W-1:0]   op;
      logic [MAC_W-1:0]  mac;
      logic [CNT_W-1:0]  cap_value;
      logic [1:0]        pace;
      int                total, seg_len, pick;
      logic              last_part;
      logic              tail_set;

      failures     = 0;
      n_responses  = 0;
      n_evictions  = 0;
      n_hits       = 0;
      n_csr_writes = 0;
      tail_set     = 1'b0;

      mac_a = rand_mac();
      mac_b = rand_mac();
      mac_c = rand_mac();
      mac_d = rand_mac();

      // Empty table: read past count, misses, and MAC zero must not hit zeroed slots.
      push_request(OP_READ,   '0,       '0, '0, '0, '0, 2'd1);
      push_request(OP_FIND,   '0,       '0, '0, '0, '0, 2'd1);
      push_request(OP_DELETE, MAC_ONES, '0, '0, '0, '0, 2'd1);
      // Field extremes, then a repeated MAC that must move to the newest slot.
      push_request(OP_ADD, '0,       '0,         '0,         '0,           '0, 2'd1);
      push_request(OP_ADD, MAC_ONES, KEY_ONES,   KEY_ONES,   {CHAN_W{1'b1}}, '1, 2'd1);
      push_request(OP_ADD, mac_a,    rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd1);
      push_request(OP_ADD, '0,       rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd1);
      push_request(OP_FIND, MAC_ONES, '0, '0, '0, '0, 2'd1);
      push_request(OP_READ, '0,       '0, '0, '0, '0, 2'd1);
      push_request(OP_READ, '0,       '0, '0, '0, '1, 2'd1);
      // Delete hit in the middle, then the same MAC misses.
      push_request(OP_DELETE, mac_a, '0, '0, '0, '0, 2'd1);
      push_request(OP_DELETE, mac_a, '0, '0, '0, '0, 2'd1);
      push_request(OP_SPARE_LO, rand_mac(), rand_key(), rand_key(), '1, '1, 2'd1);
      push_request(OP_SPARE_HI, rand_mac(), rand_key(), rand_key(), '1, '1, 2'd1);
      push_request(OP_FIND, '0, '0, '0, '0, '0, 2'd1);
      // Capacity zero acts as one: each add drops everything older.
      push_capacity('0);
      push_request(OP_ADD, mac_b, rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd2);
      push_request(OP_ADD, mac_c, rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd2);
      // Capacity above the depth, then lowered below the count.
      push_capacity('1);
      push_request(OP_ADD, mac_d,      rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd2);
      push_request(OP_ADD, rand_mac(), rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd2);
      push_request(OP_ADD, rand_mac(), rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd2);
      push_capacity(CNT_W'(2));
      push_request(OP_ADD, mac_a, rand_key(), rand_key(), CHAN_W'($urandom), '0, 2'd2);
      push_request(OP_FIND, mac_d, '0, '0, '0, '0, 2'd2);
      push_request(OP_CLEAR, rand_mac(), '0, '0, '0, '0, 2'd2);
      push_request(OP_READ, '0, '0, '0, '0, '0, 2'd2);

      // Small MAC pool so that repeats, hits and replacements happen often.
      mac_pool[0] = '0;
      mac_pool[1] = MAC_ONES;
      for (int i = 2; i < MAC_POOL; i++) mac_pool[i] = rand_mac();

      // Random segments, each under its own capacity and idling level.
      // The tail runs at full rate with the full capacity, set once.
      total = 0;
      while (total < RANDOM_ITEMS) begin
         last_part = (total >= RANDOM_ITEMS - 150);
         seg_len   = $urandom_range(60, 120);
         if (seg_len > RANDOM_ITEMS - total) seg_len = RANDOM_ITEMS - total;
         pace      = last_part ? 2'd0 : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 7))
            0:       cap_value = '0;
            1:       cap_value = CNT_W'(1);
            2:       cap_value = CNT_W'(2);
            3:       cap_value = CNT_W'(TABLE_DEPTH);
            4:       cap_value = CNT_W'(TABLE_DEPTH + 1);
            5:       cap_value = '1;
            default: cap_value = CNT_W'($urandom_range(1, TABLE_DEPTH));
         endcase
         if (!last_part || !tail_set)
            push_capacity(last_part ? CNT_W'(TABLE_DEPTH) : cap_value);
         if (last_part) tail_set = 1'b1;
         for (int k = 0; k < seg_len; k++) begin
            // Occasionally stop sending until every response is back.
            if (!last_part && $urandom_range(0, 49) == 0) push_drain();
            pick = $urandom_range(0, 99);
            op   = (pick < 42) ? OP_ADD :
                   (pick < 57) ? OP_DELETE :
                   (pick < 75) ? OP_FIND :
                   (pick < 92) ? OP_READ :
                   (pick < 95) ? OP_CLEAR :
                   OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            mac  = ($urandom_range(0, 9) < 8) ? mac_pool[$urandom_range(0, MAC_POOL - 1)]
                                              : rand_mac();
            push_request(op, mac, rand_key(), rand_key(), CHAN_W'($urandom),
                         IDX_W'($urandom), pace);
         end
         total += seg_len;
      end

      // Release reset on a falling edge after the reset cycles.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Wait for the script to drain, then for the last responses.
      while (table_steps.size() != 0 || req_valid || csr_valid) @(posedge clock);
      while (due_responses.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d responses, %0d adds with eviction, %0d find/delete hits,",
               n_responses, n_evictions, n_hits);
      $display("and %0d capacity writes across idle, stalled and full-rate segments.",
               n_csr_writes);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

endmodule
